/* sv/vsid_pkg.sv */
`default_nettype none

package vsid_pkg;

    // Field widths
    localparam int KIND_W       = 2;
    localparam int S_TDATA_W    = 64;
    localparam int M_TDATA_W    = 16;
    localparam int CHARGE_BAR_W = 7;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 14;
    localparam int TEMP_CFG_W   = 14;
    localparam int BATT_W       = 8;
    localparam int STEP_W       = 6;

    // Temperature thresholds are kept pre-scaled to raw sensor units
    localparam int TEMP_TH_W    = 18;
    localparam int RAW_W        = 16;

    localparam int BAR_SEGMENTS_DEF = 7;
    localparam int QUEUE_DEPTH_DEF  = 2;

    // Reset register values
    localparam logic [TEMP_CFG_W-1:0] MOTOR_HOT_ON_RST   = 14'd140;
    localparam logic [TEMP_CFG_W-1:0] MOTOR_HOT_OFF_RST  = 14'd135;
    localparam logic [TEMP_CFG_W-1:0] BOARD_HOT_ON_RST   = 14'd90;
    localparam logic [TEMP_CFG_W-1:0] BOARD_HOT_OFF_RST  = 14'd85;
    localparam logic [BATT_W-1:0]     BATTERY_HOT_ON_RST  = 8'd50;
    localparam logic [BATT_W-1:0]     BATTERY_HOT_OFF_RST = 8'd45;
    localparam logic [STEP_W-1:0]     CHARGE_STEP_RST     = 6'd13;

    // Decoded temperature is floor(raw / 10) - 20
    localparam int TEMP_OFFSET = 20;
    localparam int TEMP_SCALE  = 10;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MOTOR_HOT_ON    = 3'd0,
        CFG_MOTOR_HOT_OFF   = 3'd1,
        CFG_BOARD_HOT_ON    = 3'd2,
        CFG_BOARD_HOT_OFF   = 3'd3,
        CFG_BATTERY_HOT_ON  = 3'd4,
        CFG_BATTERY_HOT_OFF = 3'd5,
        CFG_CHARGE_STEP     = 3'd6
    } cfg_idx_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_TEMPS     = 2'd0,
        KIND_CHARGE    = 2'd1,
        KIND_BATTERY   = 2'd2,
        KIND_PRECHARGE = 2'd3
    } frame_kind_t;

    // Light update command, front to back
    typedef struct packed {
        logic                    motor_set;
        logic                    motor_clr;
        logic                    board_set;
        logic                    board_clr;
        logic                    batt_set;
        logic                    batt_clr;
        logic                    bar_wr;
        logic [CHARGE_BAR_W-1:0] bar;
        logic                    pre_wr;
        logic [1:0]              pre;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    // Displayed light state
    typedef struct packed {
        logic                    motor;
        logic                    board;
        logic                    batt;
        logic [CHARGE_BAR_W-1:0] bar;
        logic [1:0]              pre;
    } lights_t;

endpackage

`default_nettype wire

/* sv/vehicle_status_indicator_decoder_top.sv */
// A frame accepted on the input is classified into the command queue; the back end pops it once
// its output register is free, applies it to the light state and raises m_axis_tvalid for its status transfer.
// Throughput: one frame per cycle while the queue is not full; its depth (2 by default) sets the slack.
// Reset: aresetn synchronous, active low; all lights dark, thresholds back to defaults,
// queue emptied. No clearing pass.
`default_nettype none

module vehicle_status_indicator_decoder_top #(
    parameter int BAR_SEGMENTS = vsid_pkg::BAR_SEGMENTS_DEF,  // 1 .. 7
    parameter int QUEUE_DEPTH  = vsid_pkg::QUEUE_DEPTH_DEF    // 2 or more
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    // Register write port, index per register list
    input  wire logic                            cfg_wen,
    input  wire logic [vsid_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [vsid_pkg::CFG_DATA_W-1:0] cfg_wdata,

    // Frame input
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata, low bit up: payload_byte_0 .. payload_byte_7, 8 bits each
    input  wire logic [vsid_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: kind
    input  wire logic [vsid_pkg::KIND_W-1:0]     s_axis_tuser,

    // Light status output
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // tdata, low bit up: motor_temp_warning, board_temp_warning, battery_temp_warning,
    // charge_bar[6:0], precharge_light_zero, precharge_light_one, 4 zero pad bits
    output logic [vsid_pkg::M_TDATA_W-1:0]       m_axis_tdata
);

    vsid_pkg::cmd_t    front_cmd, back_cmd;
    vsid_pkg::q_stat_t q_stat;
    vsid_pkg::lights_t lights;
    logic              push, pop;

    // Front end: register file plus frame classifier. It only decides set/clear/write
    // per light, so its verdict never depends on the light state held in the back end.
    vsid_front #(
        .BarSegments (BAR_SEGMENTS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wen    (cfg_wen),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_kind    (s_axis_tuser),
        .in_payload (s_axis_tdata),
        .cmd        (front_cmd)
    );

    // Input transfer pushes straight into the queue
    assign s_axis_tready = !q_stat.full;
    assign push          = s_axis_tvalid && s_axis_tready;

    vsid_queue #(
        .Depth (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .pop_cmd  (back_cmd),
        .stat     (q_stat)
    );

    // Back end: applies commands in order, holds lights, drives the output transfer
    vsid_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (!q_stat.empty),
        .cmd       (back_cmd),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .lights    (lights)
    );

    assign m_axis_tdata = {4'b0000, lights.pre[1], lights.pre[0], lights.bar,
                           lights.batt, lights.board, lights.motor};

`ifndef SYNTH
    // Nothing is taken from an empty queue
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.empty |-> !pop)
        else $error("command popped from empty queue");

    // Charge bar is always a thermometer code
    a_bar_thermo: assert property (@(posedge aclk) disable iff (!aresetn)
        ((m_axis_tdata[9:3] & (m_axis_tdata[9:3] + 7'd1)) == 7'd0))
        else $error("charge bar not a thermometer code");

    // The two precharge lights are never lit together
    a_pre_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_axis_tdata[10] && m_axis_tdata[11]))
        else $error("both precharge lights lit");

    // Light state only moves when a command is applied
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !pop |=> $stable(lights))
        else $error("lights changed without a command");
`endif

endmodule

`default_nettype wire

/* sv/vsid_front.sv */
`default_nettype none

module vsid_front #(
    parameter int BarSegments = vsid_pkg::BAR_SEGMENTS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wen,
    input  wire logic [vsid_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [vsid_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [vsid_pkg::KIND_W-1:0]     in_kind,
    input  wire logic [vsid_pkg::S_TDATA_W-1:0]  in_payload,
    output vsid_pkg::cmd_t                       cmd
);

    localparam int THW = vsid_pkg::TEMP_TH_W;

    // Set threshold: floor(raw/10) - 20 > on  <=>  raw >= (on + 21) * 10
    function automatic logic signed [THW-1:0] scale_on(
        input logic [vsid_pkg::TEMP_CFG_W-1:0] v);
        logic signed [THW-1:0] t;
        t = THW'(signed'(v)) + THW'(vsid_pkg::TEMP_OFFSET + 1);
        return (t <<< 3) + (t <<< 1);
    endfunction

    // Clear threshold: floor(raw/10) - 20 < off  <=>  raw < (off + 20) * 10
    function automatic logic signed [THW-1:0] scale_off(
        input logic [vsid_pkg::TEMP_CFG_W-1:0] v);
        logic signed [THW-1:0] t;
        t = THW'(signed'(v)) + THW'(vsid_pkg::TEMP_OFFSET);
        return (t <<< 3) + (t <<< 1);
    endfunction

    logic signed [THW-1:0]           motor_on_reg, motor_off_reg;
    logic signed [THW-1:0]           board_on_reg, board_off_reg;
    logic [vsid_pkg::BATT_W-1:0]     batt_on_reg, batt_off_reg;
    logic [vsid_pkg::STEP_W-1:0]     step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            motor_on_reg  <= scale_on(vsid_pkg::MOTOR_HOT_ON_RST);
            motor_off_reg <= scale_off(vsid_pkg::MOTOR_HOT_OFF_RST);
            board_on_reg  <= scale_on(vsid_pkg::BOARD_HOT_ON_RST);
            board_off_reg <= scale_off(vsid_pkg::BOARD_HOT_OFF_RST);
            batt_on_reg   <= vsid_pkg::BATTERY_HOT_ON_RST;
            batt_off_reg  <= vsid_pkg::BATTERY_HOT_OFF_RST;
            step_reg      <= vsid_pkg::CHARGE_STEP_RST;
        end else if (cfg_wen) begin
            case (vsid_pkg::cfg_idx_t'(cfg_addr))
                vsid_pkg::CFG_MOTOR_HOT_ON:    motor_on_reg  <= scale_on(cfg_wdata);
                vsid_pkg::CFG_MOTOR_HOT_OFF:   motor_off_reg <= scale_off(cfg_wdata);
                vsid_pkg::CFG_BOARD_HOT_ON:    board_on_reg  <= scale_on(cfg_wdata);
                vsid_pkg::CFG_BOARD_HOT_OFF:   board_off_reg <= scale_off(cfg_wdata);
                vsid_pkg::CFG_BATTERY_HOT_ON:  batt_on_reg   <= cfg_wdata[vsid_pkg::BATT_W-1:0];
                vsid_pkg::CFG_BATTERY_HOT_OFF: batt_off_reg  <= cfg_wdata[vsid_pkg::BATT_W-1:0];
                vsid_pkg::CFG_CHARGE_STEP:     step_reg      <= cfg_wdata[vsid_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Raw readings, zero-extended into the signed threshold domain
    logic signed [THW-1:0] raw_motor, raw_b0, raw_b1, raw_b2;
    assign raw_motor = signed'({2'b00, in_payload[15:0]});
    assign raw_b0    = signed'({2'b00, in_payload[31:16]});
    assign raw_b1    = signed'({2'b00, in_payload[47:32]});
    assign raw_b2    = signed'({2'b00, in_payload[63:48]});

    logic [7:0] soc, batt_t, pre_state;
    assign soc       = in_payload[7:0];
    assign pre_state = in_payload[15:8];
    assign batt_t    = in_payload[39:32];

    logic [vsid_pkg::CHARGE_BAR_W-1:0] bar;
    logic [8:0]                        seg_th;

    always_comb begin
        bar    = '0;
        seg_th = '0;
        for (int i = 0; i < vsid_pkg::CHARGE_BAR_W; i++) begin
            seg_th = 9'(i + 1) * {3'b000, step_reg};
            bar[i] = (i < BarSegments) && ((step_reg == '0) || ({1'b0, soc} >= seg_th));
        end
    end

    vsid_pkg::frame_kind_t kind;
    assign kind = vsid_pkg::frame_kind_t'(in_kind);

    always_comb begin
        cmd = '0;
        case (kind)
            vsid_pkg::KIND_TEMPS: begin
                cmd.motor_set = raw_motor >= motor_on_reg;
                cmd.motor_clr = raw_motor < motor_off_reg;
                cmd.board_set = (raw_b0 >= board_on_reg) || (raw_b1 >= board_on_reg)
                              || (raw_b2 >= board_on_reg);
                cmd.board_clr = (raw_b0 < board_off_reg) && (raw_b1 < board_off_reg)
                              && (raw_b2 < board_off_reg);
            end
            vsid_pkg::KIND_CHARGE: begin
                cmd.bar_wr = 1'b1;
                cmd.bar    = bar;
            end
            vsid_pkg::KIND_BATTERY: begin
                cmd.batt_set = batt_t > batt_on_reg;
                cmd.batt_clr = batt_t < batt_off_reg;
            end
            vsid_pkg::KIND_PRECHARGE: begin
                cmd.pre_wr = 1'b1;
                cmd.pre    = (pre_state == 8'd0) ? 2'b01 :
                             (pre_state == 8'd1) ? 2'b10 : 2'b00;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

/* sv/vsid_queue.sv */
`default_nettype none

module vsid_queue #(
    parameter int Depth = vsid_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire vsid_pkg::cmd_t push_cmd,
    input  wire logic      pop,
    output vsid_pkg::cmd_t pop_cmd,
    output vsid_pkg::q_stat_t stat
);

    localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CNT_W = $clog2(Depth + 1);

    vsid_pkg::cmd_t    entry_reg [Depth];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(Depth - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(Depth));

endmodule

`default_nettype wire

/* sv/vsid_back.sv */
`default_nettype none

module vsid_back (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cmd_valid,
    input  wire vsid_pkg::cmd_t cmd,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output vsid_pkg::lights_t lights
);

    vsid_pkg::lights_t lights_reg, lights_next;
    logic              valid_reg;

    assign pop = cmd_valid && (!valid_reg || out_ready);

    // Set wins over clear; a band reading keeps the light
    always_comb begin
        lights_next = lights_reg;
        if (cmd.motor_set) begin
            lights_next.motor = 1'b1;
        end else if (cmd.motor_clr) begin
            lights_next.motor = 1'b0;
        end
        if (cmd.board_set) begin
            lights_next.board = 1'b1;
        end else if (cmd.board_clr) begin
            lights_next.board = 1'b0;
        end
        if (cmd.batt_set) begin
            lights_next.batt = 1'b1;
        end else if (cmd.batt_clr) begin
            lights_next.batt = 1'b0;
        end
        if (cmd.bar_wr) begin
            lights_next.bar = cmd.bar;
        end
        if (cmd.pre_wr) begin
            lights_next.pre = cmd.pre;
        end
    end

    // Light state doubles as the result register: it only moves on a pop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lights_reg <= '0;
            valid_reg  <= 1'b0;
        end else if (pop) begin
            lights_reg <= lights_next;
            valid_reg  <= 1'b1;
        end else if (out_ready) begin
            valid_reg  <= 1'b0;
        end
    end

    assign out_valid = valid_reg;
    assign lights    = lights_reg;

endmodule

`default_nettype wire
